// ===== src/assert_macros.svh =====
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SLI_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SLI_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/sli_pkg.sv =====
// Types and constants of the segment crossing pipeline.
package sli_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int FRAC_W     = FRAC_BITS + 1;
    localparam int COORD_W    = 32;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int PROD_W     = DIFF_W + COORD_W;
    localparam int DOT_W      = PROD_W + 1;
    localparam int LEN_W      = 63;
    localparam int LEN_LO_W   = 32;
    localparam int LEN_HI_W   = LEN_W - LEN_LO_W;
    localparam int EPS_W      = 16;
    localparam int BAND_LO_W  = EPS_W + LEN_LO_W;
    localparam int BAND_HI_W  = EPS_W + LEN_HI_W;
    localparam int BAND_W     = EPS_W + LEN_W;
    localparam int SCL_W      = DOT_W + FRAC_BITS;
    localparam int WM_W       = DOT_W;
    localparam int WM_LO_W    = 32;
    localparam int WM_HI_W    = WM_W - WM_LO_W;
    localparam int WP_W       = 2 * WM_W;
    localparam int DIV_W      = WP_W + FRAC_BITS;
    localparam int DIV_STAGES = FRAC_BITS + 1;
    localparam int PLACE_W    = COORD_W + FRAC_W + 1;
    localparam int OFF_W      = PLACE_W - FRAC_BITS;
    localparam int SUM_W      = OFF_W + 1;
    localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(1) << FRAC_BITS;

    localparam int DATA_W  = 32;
    localparam int PADDR_W = 3;
    localparam logic REG_SIDE_EPS = 1'b0;
    localparam logic REG_EQ_EPS   = 1'b1;

    typedef struct packed {
        logic signed [COORD_W-1:0] first_start_x;
        logic signed [COORD_W-1:0] first_start_y;
        logic signed [COORD_W-1:0] first_dir_x;
        logic signed [COORD_W-1:0] first_dir_y;
        logic        [LEN_W-1:0]   first_len_sq;
        logic signed [COORD_W-1:0] second_start_x;
        logic signed [COORD_W-1:0] second_start_y;
        logic signed [COORD_W-1:0] second_end_x;
        logic signed [COORD_W-1:0] second_end_y;
    } in_item_t;

    typedef struct packed {
        logic                      hit;
        logic        [FRAC_W-1:0]  cross_fraction;
        logic signed [COORD_W-1:0] cross_x;
        logic signed [COORD_W-1:0] cross_y;
    } out_item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x0;
        logic signed [COORD_W-1:0] y0;
        logic signed [COORD_W-1:0] dx;
        logic signed [COORD_W-1:0] dy;
    } geo_t;

    typedef struct packed {
        geo_t geo;
        logic miss;
    } side_t;

endpackage

// ===== src/sli_wmul.sv =====
// Two-stage signed wide multiplier built from four partial products.
module sli_wmul (
    input  logic                           aclk,
    input  logic                           en,
    input  logic signed [sli_pkg::WM_W-1:0] a,
    input  logic signed [sli_pkg::WM_W-1:0] b,
    output logic signed [sli_pkg::WP_W-1:0] p
);
    import sli_pkg::*;

    localparam int LH_W = WM_LO_W + 1 + WM_HI_W;
    localparam int HH_W = 2 * WM_HI_W;

    logic        [2*WM_LO_W-1:0] ll_reg;
    logic signed [LH_W-1:0]      lh_reg, hl_reg;
    logic signed [HH_W-1:0]      hh_reg;
    logic        [WP_W-1:0]      p_reg;
    logic signed [LH_W:0]        mid;

    always_ff @(posedge aclk) begin
        if (en) begin
            ll_reg <= a[WM_LO_W-1:0] * b[WM_LO_W-1:0];
            lh_reg <= $signed({1'b0, a[WM_LO_W-1:0]}) * $signed(b[WM_W-1:WM_LO_W]);
            hl_reg <= $signed(a[WM_W-1:WM_LO_W]) * $signed({1'b0, b[WM_LO_W-1:0]});
            hh_reg <= $signed(a[WM_W-1:WM_LO_W]) * $signed(b[WM_W-1:WM_LO_W]);
            p_reg  <= {hh_reg, {(2*WM_LO_W){1'b0}}}
                    + {{(WP_W-LH_W-1-WM_LO_W){mid[LH_W]}}, mid, {WM_LO_W{1'b0}}}
                    + {{(WP_W-2*WM_LO_W){1'b0}}, ll_reg};
        end
    end

    assign mid = (LH_W+1)'(lh_reg) + (LH_W+1)'(hl_reg);
    assign p   = $signed(p_reg);

endmodule

// ===== src/sli_div.sv =====
// Pipelined restoring divider: one quotient bit per stage.
module sli_div (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             en,
    input  logic                             in_vld,
    input  logic [sli_pkg::DIV_W-1:0]        in_rem,
    input  logic [sli_pkg::DIV_W-1:0]        in_den,
    input  sli_pkg::side_t                   in_side,
    output logic                             out_vld,
    output logic [sli_pkg::FRAC_W-1:0]       out_frac,
    output sli_pkg::side_t                   out_side
);
    import sli_pkg::*;

    logic              vld_reg  [DIV_STAGES];
    logic [DIV_W-1:0]  rem_reg  [DIV_STAGES];
    logic [DIV_W-1:0]  den_reg  [DIV_STAGES];
    logic [FRAC_W-1:0] frac_reg [DIV_STAGES];
    side_t             side_reg [DIV_STAGES];

    for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
        localparam int BIT = FRAC_BITS - i;
        logic              vld_in;
        logic [DIV_W-1:0]  rem_in, den_in, trial;
        logic [FRAC_W-1:0] frac_in;
        side_t             side_in;
        logic              take;

        if (i == 0) begin : g_first
            assign vld_in  = in_vld;
            assign rem_in  = in_rem;
            assign den_in  = in_den;
            assign frac_in = '0;
            assign side_in = in_side;
        end else begin : g_rest
            assign vld_in  = vld_reg[i-1];
            assign rem_in  = rem_reg[i-1];
            assign den_in  = den_reg[i-1];
            assign frac_in = frac_reg[i-1];
            assign side_in = side_reg[i-1];
        end

        assign trial = den_in << BIT;
        assign take  = rem_in >= trial;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i] <= 1'b0;
            end else if (en) begin
                vld_reg[i] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i]  <= take ? rem_in - trial : rem_in;
                den_reg[i]  <= den_in;
                frac_reg[i] <= frac_in | (take ? (FRAC_W'(1) << BIT) : '0);
                side_reg[i] <= side_in;
            end
        end
    end

    assign out_vld  = vld_reg[DIV_STAGES-1];
    assign out_frac = frac_reg[DIV_STAGES-1];
    assign out_side = side_reg[DIV_STAGES-1];

endmodule

// ===== src/sli_obuf.sv =====
// Two-entry output buffer that decouples the pipeline from the result channel.
module sli_obuf (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  sli_pkg::out_item_t push_item,
    output logic               room,
    output logic               m_valid,
    input  logic               m_ready,
    output sli_pkg::out_item_t m_data
);
    import sli_pkg::*;

    logic [1:0] count_reg, count_next;
    out_item_t  head_reg, tail_reg;
    logic       pop;

    assign pop     = m_valid && m_ready;
    assign m_valid = count_reg != 2'd0;
    assign m_data  = head_reg;
    assign room    = count_reg != 2'd2;

    always_comb begin
        count_next = count_reg;
        priority if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        priority if (pop) begin
            head_reg <= (count_reg == 2'd2) ? tail_reg : push_item;
            if (count_reg == 2'd2 && push) begin
                tail_reg <= push_item;
            end
        end else if (push) begin
            if (count_reg == 2'd0) begin
                head_reg <= push_item;
            end else begin
                tail_reg <= push_item;
            end
        end
    end

endmodule

// ===== src/segment_line_intersection.sv =====
// Top level: segment crossing test in fixed point, a pipelined design.
// Throughput: one item per cycle; the stall point is the two-entry output buffer.
// The quotient comes from a 17-stage restoring divider, one bit per stage.
// Reset (aresetn low, synchronous) empties the pipeline and buffer and sets
// both epsilon registers to 1.
`include "assert_macros.svh"

module segment_line_intersection (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  sli_pkg::in_item_t               s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output sli_pkg::out_item_t              m_data,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [sli_pkg::PADDR_W-1:0]     paddr,
    input  logic [sli_pkg::DATA_W-1:0]      pwdata,
    output logic [sli_pkg::DATA_W-1:0]      prdata,
    output logic                            pready
);
    import sli_pkg::*;

    // Saturate a widened sum back into the coordinate range.
    function automatic logic signed [COORD_W-1:0] sat_coord(logic signed [SUM_W-1:0] v);
        logic hi_same;
        hi_same = (v[SUM_W-1:COORD_W-1] == '0) || (v[SUM_W-1:COORD_W-1] == '1);
        if (hi_same) begin
            return v[COORD_W-1:0];
        end else if (v[SUM_W-1]) begin
            return {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            return {1'b0, {(COORD_W-1){1'b1}}};
        end
    endfunction

    // ---------------- configuration registers ----------------
    logic [EPS_W-1:0] side_eps_reg, eq_eps_reg;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_eps_reg <= EPS_W'(1);
            eq_eps_reg   <= EPS_W'(1);
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_SIDE_EPS: side_eps_reg <= pwdata[EPS_W-1:0];
                REG_EQ_EPS:   eq_eps_reg   <= pwdata[EPS_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_SIDE_EPS: prdata = DATA_W'(side_eps_reg);
            REG_EQ_EPS:   prdata = DATA_W'(eq_eps_reg);
        endcase
    end

    // ---------------- pipeline control ----------------
    // The whole pipeline advances together whenever the output buffer has room.
    logic en;
    assign s_ready = en;

    // Stage 1: endpoints relative to the first segment's start.
    logic                     s1_vld_reg;
    geo_t                     s1_geo_reg;
    logic [LEN_W-1:0]         s1_len_reg;
    logic signed [DIFF_W-1:0] s1_cdx_reg, s1_cdy_reg, s1_ddx_reg, s1_ddy_reg;

    // Stage 2: cross products and epsilon-times-length partials.
    logic                        s2_vld_reg;
    geo_t                        s2_geo_reg;
    logic [LEN_W-1:0]            s2_len_reg;
    logic signed [PROD_W-1:0]    s2_cxdx_reg, s2_cydy_reg, s2_cydx_reg, s2_cxdy_reg;
    logic signed [PROD_W-1:0]    s2_dxdx_reg, s2_dydy_reg, s2_dydx_reg, s2_dxdy_reg;
    logic [BAND_LO_W-1:0]        s2_sb_lo_reg, s2_eb_lo_reg;
    logic [BAND_HI_W-1:0]        s2_sb_hi_reg, s2_eb_hi_reg;

    // Stage 3: along and perpendicular coordinates, bands.
    logic                    s3_vld_reg;
    geo_t                    s3_geo_reg;
    logic [LEN_W-1:0]        s3_len_reg;
    logic signed [DOT_W-1:0] s3_ac_reg, s3_bc_reg, s3_ad_reg, s3_bd_reg;
    logic [BAND_W-1:0]       s3_band_reg, s3_eqband_reg;

    // Stage 4: side band test, offset difference; feeds the wide multipliers.
    logic                    s4_vld_reg;
    side_t                   s4_side_reg;
    logic [LEN_W-1:0]        s4_len_reg;
    logic signed [DOT_W-1:0] s4_ac_reg, s4_bc_reg, s4_ad_reg, s4_bd_reg, s4_diff_reg;
    logic [BAND_W-1:0]       s4_eqband_reg;
    logic signed [SCL_W-1:0] bc_scl, bd_scl, band_s;
    logic                    side_miss;

    assign bc_scl = {s3_bc_reg, {FRAC_BITS{1'b0}}};
    assign bd_scl = {s3_bd_reg, {FRAC_BITS{1'b0}}};
    assign band_s = $signed(SCL_W'(s3_band_reg));
    assign side_miss = (bc_scl < -band_s && bd_scl < -band_s)
                    || (band_s < bc_scl && band_s < bd_scl);

    // Stage 5: magnitude of the offset difference.
    logic              s5_vld_reg;
    side_t             s5_side_reg;
    logic [DOT_W-1:0]  s5_absd_reg;
    logic              s5_dzero_reg;
    logic [BAND_W-1:0] s5_eqband_reg;

    // Stage 6: equal-offset test.
    logic  s6_vld_reg;
    side_t s6_side_reg;
    logic  eq_miss;

    assign eq_miss = s5_dzero_reg
                  || ({s5_absd_reg, {FRAC_BITS{1'b0}}} < SCL_W'(s5_eqband_reg));

    // Wide products, aligned with stage 6.
    logic signed [WP_W-1:0] p_acbd, p_adbc, p_den;

    sli_wmul u_mul_acbd (.aclk(aclk), .en(en), .a(s4_ac_reg), .b(s4_bd_reg), .p(p_acbd));
    sli_wmul u_mul_adbc (.aclk(aclk), .en(en), .a(s4_ad_reg), .b(s4_bc_reg), .p(p_adbc));
    sli_wmul u_mul_den  (.aclk(aclk), .en(en), .a($signed(WM_W'(s4_len_reg))),
                         .b(s4_diff_reg), .p(p_den));

    // Stages 7 to 9: numerator, sign fix, range test.
    logic                   s7_vld_reg, s8_vld_reg, s9_vld_reg;
    side_t                  s7_side_reg, s8_side_reg, s9_side_reg;
    logic signed [WP_W-1:0] s7_num_reg, s7_den_reg, s8_num_reg, s8_den_reg;
    logic [DIV_W-1:0]       s9_rem_reg, s9_den_reg;
    side_t                  s9_side_next;

    always_comb begin
        s9_side_next = s8_side_reg;
        s9_side_next.miss = s8_side_reg.miss || s8_num_reg < 0 || s8_den_reg < s8_num_reg;
    end

    // Divider and placement.
    logic              dv_vld;
    logic [FRAC_W-1:0] dv_frac;
    side_t             dv_side;

    sli_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_vld   (s9_vld_reg),
        .in_rem   (s9_rem_reg),
        .in_den   (s9_den_reg),
        .in_side  (s9_side_reg),
        .out_vld  (dv_vld),
        .out_frac (dv_frac),
        .out_side (dv_side)
    );

    logic                     p1_vld_reg;
    side_t                    p1_side_reg;
    logic [FRAC_W-1:0]        p1_frac_reg;
    logic signed [PLACE_W-1:0] p1_px_reg, p1_py_reg;

    // Final assembly: floor shift, add start, saturate, zero on a miss.
    out_item_t              res_item;
    logic signed [SUM_W-1:0] sum_x, sum_y;

    assign sum_x = SUM_W'(p1_side_reg.geo.x0) + SUM_W'($signed(p1_px_reg[PLACE_W-1:FRAC_BITS]));
    assign sum_y = SUM_W'(p1_side_reg.geo.y0) + SUM_W'($signed(p1_py_reg[PLACE_W-1:FRAC_BITS]));

    always_comb begin
        res_item = '0;
        if (!p1_side_reg.miss) begin
            res_item.hit            = 1'b1;
            res_item.cross_fraction = p1_frac_reg;
            res_item.cross_x        = sat_coord(sum_x);
            res_item.cross_y        = sat_coord(sum_y);
        end
    end

    sli_obuf u_obuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (en && p1_vld_reg),
        .push_item (res_item),
        .room      (en),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // ---------------- valid bits ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            s5_vld_reg <= 1'b0;
            s6_vld_reg <= 1'b0;
            s7_vld_reg <= 1'b0;
            s8_vld_reg <= 1'b0;
            s9_vld_reg <= 1'b0;
            p1_vld_reg <= 1'b0;
        end else if (en) begin
            s1_vld_reg <= s_valid;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
            s5_vld_reg <= s4_vld_reg;
            s6_vld_reg <= s5_vld_reg;
            s7_vld_reg <= s6_vld_reg;
            s8_vld_reg <= s7_vld_reg;
            s9_vld_reg <= s8_vld_reg;
            p1_vld_reg <= dv_vld;
        end
    end

    // ---------------- payload ----------------
    always_ff @(posedge aclk) begin
        if (en) begin
            // stage 1
            s1_geo_reg.x0 <= s_data.first_start_x;
            s1_geo_reg.y0 <= s_data.first_start_y;
            s1_geo_reg.dx <= s_data.first_dir_x;
            s1_geo_reg.dy <= s_data.first_dir_y;
            s1_len_reg    <= s_data.first_len_sq;
            s1_cdx_reg <= DIFF_W'(s_data.second_start_x) - DIFF_W'(s_data.first_start_x);
            s1_cdy_reg <= DIFF_W'(s_data.second_start_y) - DIFF_W'(s_data.first_start_y);
            s1_ddx_reg <= DIFF_W'(s_data.second_end_x) - DIFF_W'(s_data.first_start_x);
            s1_ddy_reg <= DIFF_W'(s_data.second_end_y) - DIFF_W'(s_data.first_start_y);

            // stage 2
            s2_geo_reg   <= s1_geo_reg;
            s2_len_reg   <= s1_len_reg;
            s2_cxdx_reg  <= s1_cdx_reg * s1_geo_reg.dx;
            s2_cydy_reg  <= s1_cdy_reg * s1_geo_reg.dy;
            s2_cydx_reg  <= s1_cdy_reg * s1_geo_reg.dx;
            s2_cxdy_reg  <= s1_cdx_reg * s1_geo_reg.dy;
            s2_dxdx_reg  <= s1_ddx_reg * s1_geo_reg.dx;
            s2_dydy_reg  <= s1_ddy_reg * s1_geo_reg.dy;
            s2_dydx_reg  <= s1_ddy_reg * s1_geo_reg.dx;
            s2_dxdy_reg  <= s1_ddx_reg * s1_geo_reg.dy;
            s2_sb_lo_reg <= side_eps_reg * s1_len_reg[LEN_LO_W-1:0];
            s2_sb_hi_reg <= side_eps_reg * s1_len_reg[LEN_W-1:LEN_LO_W];
            s2_eb_lo_reg <= eq_eps_reg * s1_len_reg[LEN_LO_W-1:0];
            s2_eb_hi_reg <= eq_eps_reg * s1_len_reg[LEN_W-1:LEN_LO_W];

            // stage 3
            s3_geo_reg    <= s2_geo_reg;
            s3_len_reg    <= s2_len_reg;
            s3_ac_reg     <= DOT_W'(s2_cxdx_reg) + DOT_W'(s2_cydy_reg);
            s3_bc_reg     <= DOT_W'(s2_cydx_reg) - DOT_W'(s2_cxdy_reg);
            s3_ad_reg     <= DOT_W'(s2_dxdx_reg) + DOT_W'(s2_dydy_reg);
            s3_bd_reg     <= DOT_W'(s2_dydx_reg) - DOT_W'(s2_dxdy_reg);
            s3_band_reg   <= {s2_sb_hi_reg, {LEN_LO_W{1'b0}}} + BAND_W'(s2_sb_lo_reg);
            s3_eqband_reg <= {s2_eb_hi_reg, {LEN_LO_W{1'b0}}} + BAND_W'(s2_eb_lo_reg);

            // stage 4: zero length or both ends clear of the band on one side
            s4_side_reg.geo  <= s3_geo_reg;
            s4_side_reg.miss <= (s3_len_reg == '0) || side_miss;
            s4_len_reg       <= s3_len_reg;
            s4_ac_reg        <= s3_ac_reg;
            s4_bc_reg        <= s3_bc_reg;
            s4_ad_reg        <= s3_ad_reg;
            s4_bd_reg        <= s3_bd_reg;
            s4_diff_reg      <= s3_bd_reg - s3_bc_reg;
            s4_eqband_reg    <= s3_eqband_reg;

            // stage 5
            s5_side_reg   <= s4_side_reg;
            s5_absd_reg   <= s4_diff_reg[DOT_W-1] ? $unsigned(-s4_diff_reg)
                                                  : $unsigned(s4_diff_reg);
            s5_dzero_reg  <= s4_diff_reg == '0;
            s5_eqband_reg <= s4_eqband_reg;

            // stage 6: offsets too close to give a usable crossing
            s6_side_reg.geo  <= s5_side_reg.geo;
            s6_side_reg.miss <= s5_side_reg.miss || eq_miss;

            // stage 7: num = ac*bd - ad*bc, den = L*(bd - bc)
            s7_side_reg <= s6_side_reg;
            s7_num_reg  <= p_acbd - p_adbc;
            s7_den_reg  <= p_den;

            // stage 8: make the denominator positive
            s8_side_reg <= s7_side_reg;
            s8_num_reg  <= s7_den_reg < 0 ? -s7_num_reg : s7_num_reg;
            s8_den_reg  <= s7_den_reg < 0 ? -s7_den_reg : s7_den_reg;

            // stage 9: fraction must lie in 0..1
            s9_side_reg <= s9_side_next;
            s9_rem_reg  <= {$unsigned(s8_num_reg), {FRAC_BITS{1'b0}}};
            s9_den_reg  <= DIV_W'($unsigned(s8_den_reg));

            // placement multiply
            p1_side_reg <= dv_side;
            p1_frac_reg <= dv_frac;
            p1_px_reg   <= dv_side.geo.dx * $signed({1'b0, dv_frac});
            p1_py_reg   <= dv_side.geo.dy * $signed({1'b0, dv_frac});
        end
    end

    // ---------------- checks ----------------
    `SLI_ASSERT_IMP(a_hit_frac_range, m_valid && m_data.hit, m_data.cross_fraction <= FRAC_ONE, "fraction above one on a hit")
    `SLI_ASSERT_IMP(a_miss_zero, m_valid && !m_data.hit, m_data.cross_fraction == '0 && m_data.cross_x == '0 && m_data.cross_y == '0, "miss result carries nonzero fields")
    `SLI_ASSERT_IMP(a_stall_needs_result, !s_ready, m_valid, "input stalled with no result pending")
    `SLI_ASSERT_NXT(a_full_holds, !s_ready && m_valid && !m_ready, !s_ready, "full buffer freed without a pop")

endmodule

// ===== sim/tb_segment_line_intersection.sv =====
// Self-checking testbench for the segment crossing pipeline.
`timescale 1ns / 100ps

module tb_segment_line_intersection;
    import sli_pkg::*;

    typedef logic signed [255:0] big_t;

    // Expected crossing results, predicted from each accepted item.
    class crossing_board;
        out_item_t pending[$];
        longint side_eps = 1;
        longint eq_eps = 1;
        int errors = 0;

        // Offset along one axis, floored, then saturated to 32 bits.
        function logic signed [31:0] place_coord(longint start, longint dir, longint frac);
            longint p;
            longint s;
            p = dir * frac;
            s = start + (p >>> FRAC_BITS);
            if (s > 64'sd2147483647) s = 64'sd2147483647;
            if (s < -64'sd2147483648) s = -64'sd2147483648;
            return s[31:0];
        endfunction

        function out_item_t predict_crossing(in_item_t it);
            out_item_t res;
            big_t x0, y0, dx, dy, cdx, cdy, ddx, ddy, len, ac, bc, ad, bd;
            big_t band, bc2, bd2, diff, num, den, q, se, ee;
            res = '0;
            if (it.first_len_sq == 0) return res;
            x0 = it.first_start_x;
            y0 = it.first_start_y;
            dx = it.first_dir_x;
            dy = it.first_dir_y;
            len = $signed({193'b0, it.first_len_sq});
            se = side_eps;
            ee = eq_eps;
            cdx = big_t'(it.second_start_x) - x0;
            cdy = big_t'(it.second_start_y) - y0;
            ddx = big_t'(it.second_end_x) - x0;
            ddy = big_t'(it.second_end_y) - y0;
            ac = cdx * dx + cdy * dy;
            bc = cdy * dx - cdx * dy;
            ad = ddx * dx + ddy * dy;
            bd = ddy * dx - ddx * dy;
            // Side band: drop when both ends sit beyond it on one side.
            band = se * len;
            bc2 = bc <<< FRAC_BITS;
            bd2 = bd <<< FRAC_BITS;
            if (bc2 < -band && bd2 < -band) return res;
            if (band < bc2 && band < bd2) return res;
            // Nearly equal offsets mean the segments run parallel.
            diff = bc - bd;
            if (diff == 0) return res;
            if (diff < 0) diff = -diff;
            if ((diff <<< FRAC_BITS) < ee * len) return res;
            num = ac * bd - ad * bc;
            den = len * (bd - bc);
            if (den < 0) begin
                den = -den;
                num = -num;
            end
            if (num < 0 || den < num) return res;
            q = (num <<< FRAC_BITS) / den;
            res.hit = 1'b1;
            res.cross_fraction = q[FRAC_W-1:0];
            res.cross_x = place_coord(it.first_start_x, it.first_dir_x, q[FRAC_W-1:0]);
            res.cross_y = place_coord(it.first_start_y, it.first_dir_y, q[FRAC_W-1:0]);
            return res;
        endfunction

        function void note_item(in_item_t it);
            pending.push_back(predict_crossing(it));
        endfunction

        function void check_result(out_item_t got);
            out_item_t exp_r;
            if (pending.size() == 0) begin
                $error("unexpected result %h", got);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got.hit !== exp_r.hit) begin
                $error("hit: expected %0d, got %0d", exp_r.hit, got.hit);
                errors++;
            end
            if (got.cross_fraction !== exp_r.cross_fraction) begin
                $error("cross_fraction: expected %0d, got %0d",
                       exp_r.cross_fraction, got.cross_fraction);
                errors++;
            end
            if (got.cross_x !== exp_r.cross_x) begin
                $error("cross_x: expected %0d, got %0d", exp_r.cross_x, got.cross_x);
                errors++;
            end
            if (got.cross_y !== exp_r.cross_y) begin
                $error("cross_y: expected %0d, got %0d", exp_r.cross_y, got.cross_y);
                errors++;
            end
        endfunction
    endclass

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    in_item_t s_data;
    logic m_valid;
    logic m_ready;
    out_item_t m_data;
    logic psel;
    logic penable;
    logic pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic pready;

    crossing_board board;
    int burst_left;

    segment_line_intersection dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hard stop well past the slowest legal run.
    initial begin
        #5ms;
        $display("TEST FAILED");
        $finish;
    end

    // Receiver: stall in runs, with some long stretches always ready.
    initial begin
        int mode;
        int run;
        m_ready = 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            run = $urandom_range(1, 40);
            repeat (run) begin
                @(posedge aclk);
                case (mode)
                    0: begin
                        m_ready <= 1'b1;
                    end
                    1: begin
                        m_ready <= 1'b0;
                    end
                    default: begin
                        m_ready <= ($urandom_range(0, 2) != 0);
                    end
                endcase
            end
        end
    end

    // Check every result taken by the receiver.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            board.check_result(m_data);
        end
    end

    // Register write: setup cycle, then access cycle.
    task automatic write_reg(logic idx, logic [15:0] value);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {16'b0, value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_SIDE_EPS) begin
            board.side_eps = value;
        end else begin
            board.eq_eps = value;
        end
    endtask

    // Hold the item until accepted; drop valid only when a gap follows.
    task automatic send_item(in_item_t it);
        int gap;
        s_valid <= 1'b1;
        s_data <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_item(it);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 30);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    // Wait out every pending result plus the pipeline depth.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    function automatic in_item_t make_seg(longint x0, longint y0, longint dx, longint dy,
                                          longint ax, longint ay, longint bx, longint by);
        in_item_t it;
        it.first_start_x = 32'(x0);
        it.first_start_y = 32'(y0);
        it.first_dir_x = 32'(dx);
        it.first_dir_y = 32'(dy);
        it.first_len_sq = 63'(dx * dx + dy * dy);
        it.second_start_x = 32'(ax);
        it.second_start_y = 32'(ay);
        it.second_end_x = 32'(bx);
        it.second_end_y = 32'(by);
        return it;
    endfunction

    function automatic longint rnd_signed(int bits);
        longint v;
        v = {$urandom, $urandom};
        return v >>> (64 - bits);
    endfunction

    // Mostly well-formed crossings near the first segment; the rest is noise.
    function automatic in_item_t random_item();
        in_item_t it;
        logic [319:0] raw;
        longint x0, y0, dx, dy, span;
        int shape;
        shape = $urandom_range(0, 9);
        if (shape < 2) begin
            raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom, $urandom, $urandom};
            it = raw[$bits(in_item_t)-1:0];
            if (shape == 1) it.first_len_sq = it.first_dir_x * it.first_dir_x;
            return it;
        end
        span = (shape == 9) ? 31 : $urandom_range(4, 22);
        x0 = rnd_signed(span);
        y0 = rnd_signed(span);
        dx = rnd_signed(span);
        dy = rnd_signed(span);
        if (shape == 8) dy = 0;
        it = make_seg(x0, y0, dx, dy,
                      x0 + dx / 2 + rnd_signed(span), y0 + dy / 2 + rnd_signed(span),
                      x0 + dx / 2 + rnd_signed(span), y0 + dy / 2 + rnd_signed(span));
        if (shape == 7) begin
            // Second segment parallel to the first: equal offsets.
            it.second_end_x = 32'(it.second_start_x + dx);
            it.second_end_y = 32'(it.second_start_y + dy);
        end
        return it;
    endfunction

    task automatic directed_items();
        in_item_t it;
        longint one;
        one = 65536;
        // Zero length.
        it = make_seg(0, 0, one, 0, 0, -one, one, one);
        it.first_len_sq = 0;
        send_item(it);
        // Crossing exactly at the start and exactly at the end.
        send_item(make_seg(0, 0, one, 0, 0, -one, 0, one));
        send_item(make_seg(0, 0, one, 0, one, -one, one, one));
        // Just past either end.
        send_item(make_seg(0, 0, one, 0, -1, -one, -1, one));
        send_item(make_seg(0, 0, one, 0, one + 1, -one, one + 1, one));
        // Midpoint, diagonal, negative direction.
        send_item(make_seg(0, 0, one, 0, one / 2, one, one / 2, -one));
        send_item(make_seg(-one, -one, 2 * one, 2 * one, -one, one, one, -one));
        send_item(make_seg(one, one, -3, -5, 0, one, 2 * one, -one));
        // Both ends on one side, and one end inside the band.
        send_item(make_seg(0, 0, one, 0, 0, one, one, 2 * one));
        send_item(make_seg(0, 0, one, 0, 0, -one, one, -2 * one));
        send_item(make_seg(0, 0, one, 0, 0, 0, one, one));
        send_item(make_seg(0, 0, one, 0, one / 2, 1, one / 2, one));
        // Parallel and nearly parallel.
        send_item(make_seg(0, 0, one, 0, 0, one, one, one));
        send_item(make_seg(0, 0, one, 0, 0, 0, one, 0));
        send_item(make_seg(0, 0, one, 0, 0, 1, one, 0));
        // Field extremes, saturation of the crossing point.
        send_item(make_seg(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                           -32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, -32'sh80000000));
        send_item(make_seg(-32'sh80000000, -32'sh80000000, -32'sh80000000, 32'sh7fffffff,
                           32'sh7fffffff, 32'sh7fffffff, -32'sh80000000, -32'sh80000000));
        send_item(make_seg(32'sh7fff0000, 0, 32'sh7fffffff, 0, 32'sh7fff0001, -one,
                           32'sh7fff0001, one));
        it = make_seg(0, 0, one, 0, one / 2, one, one / 2, -one);
        it.first_len_sq = '1;
        send_item(it);
        it.first_len_sq = 63'd1;
        send_item(it);
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        burst_left = 0;
        board = new();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset values first, then zero, full range and random settings.
        directed_items();
        for (int phase = 0; phase < 5; phase++) begin
            if (phase > 0) begin
                drain();
                case (phase)
                    1: begin
                        write_reg(REG_SIDE_EPS, 16'd0);
                        write_reg(REG_EQ_EPS, 16'd0);
                    end
                    2: begin
                        write_reg(REG_SIDE_EPS, 16'hffff);
                        write_reg(REG_EQ_EPS, 16'hffff);
                    end
                    default: begin
                        write_reg(REG_SIDE_EPS, 16'($urandom));
                        write_reg(REG_EQ_EPS, 16'($urandom_range(0, 300)));
                    end
                endcase
                if (phase < 3) directed_items();
            end
            repeat (100) send_item(random_item());
        end
        drain();

        if (board.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
